### hw/rtl/bpd_pkg.sv
// ----------------------------------------------------------------------------
// bpd_pkg
// shared widths, register indexes, reset values and control structs for the
// breath pressure detector
// ----------------------------------------------------------------------------
package bpd_pkg;

   // field widths
   localparam int SAMPLE_W  = 12;
   localparam int GAIN_W    = 20;
   localparam int THRESH_W  = 18;
   localparam int STABLE_W  = 8;
   localparam int P_W       = 19;   // signed q8 pressure
   localparam int BASE_W    = 19;   // baseline sum, wraps
   localparam int D_W       = 21;   // signed raw*cal - baseline
   localparam int PROD_W    = 42;   // d * gain
   localparam int GAIN_FRAC = 16;   // shift after the gain multiply
   localparam int RUN_W     = 8;

   // csr port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 20;

   localparam logic [CSR_ADDR_W-1:0] CSR_PRESSURE_GAIN   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD_Q8    = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_STABLE_REQUIRED = 2'd2;

   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 20'd38029;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd256;
   localparam logic [STABLE_W-1:0] STABLE_RESET = 8'd5;

   // default sizes
   localparam int WINDOW_DEFAULT      = 10;
   localparam int CAL_SAMPLES_DEFAULT = 100;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic mult;
      logic store;
      logic sum_step;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cal_active;
      logic sum_last;
      logic div_last;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/bpd_ctrl.sv
// ----------------------------------------------------------------------------
// bpd_ctrl
// sequencer: accept, multiply, store, ring sum, divide, deliver
// ----------------------------------------------------------------------------
module bpd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bpd_pkg::status_type status,
   output bpd_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MULT  = 3'd1;
   localparam logic [2:0] S_STORE = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_DIVI  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               // calibration words skip the whole pressure path
               state_in = status.cal_active ? S_DONE : S_MULT;
            end
         end
         S_MULT: begin
            cmd.mult = 1'b1;
            state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) state_in = S_DIVI;
         end
         S_DIVI: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### hw/rtl/bpd_datapath.sv
// ----------------------------------------------------------------------------
// bpd_datapath
// baseline, gain multiply, averaging ring, radix-4 divider, run detector,
// config registers and the result register
// ----------------------------------------------------------------------------
module bpd_datapath #(
   parameter int WINDOW      = bpd_pkg::WINDOW_DEFAULT,
   parameter int CAL_SAMPLES = bpd_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bpd_pkg::cmd_type                      cmd,
   output bpd_pkg::status_type                   status,
   input  logic [bpd_pkg::SAMPLE_W-1:0]          pressure_sample,
   input  logic [bpd_pkg::SAMPLE_W-1:0]          gas_sample,
   input  logic                                  csr_we,
   input  logic [bpd_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [bpd_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic                                  calibrating,
   output logic                                  blowing,
   output logic signed [bpd_pkg::P_W-1:0]        filtered_pressure,
   output logic [bpd_pkg::SAMPLE_W-1:0]          gas_reading
);

   localparam int P_W       = bpd_pkg::P_W;
   localparam int CNT_W     = $clog2(WINDOW + 1);
   localparam int IDX_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SUM_W     = P_W + CNT_W;
   localparam int DIV_STEPS = (SUM_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int STEP_W    = $clog2(DIV_STEPS);
   localparam int CAL_W     = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES + 1) : 1;
   localparam int PROD_W    = bpd_pkg::PROD_W;
   localparam int BASE_W    = bpd_pkg::BASE_W;
   localparam int D_W       = bpd_pkg::D_W;

   // config
   logic [bpd_pkg::GAIN_W-1:0]   gain_ff;
   logic [bpd_pkg::THRESH_W-1:0] thresh_ff;
   logic [bpd_pkg::STABLE_W-1:0] stable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= bpd_pkg::GAIN_RESET;
         thresh_ff <= bpd_pkg::THRESH_RESET;
         stable_ff <= bpd_pkg::STABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            bpd_pkg::CSR_PRESSURE_GAIN:   gain_ff   <= csr_wdata[bpd_pkg::GAIN_W-1:0];
            bpd_pkg::CSR_THRESHOLD_Q8:    thresh_ff <= csr_wdata[bpd_pkg::THRESH_W-1:0];
            bpd_pkg::CSR_STABLE_REQUIRED: stable_ff <= csr_wdata[bpd_pkg::STABLE_W-1:0];
            default: ;
         endcase
      end
   end

   // state
   logic [BASE_W-1:0]               baseline_ff;
   logic [CAL_W-1:0]                cal_taken_ff;
   logic [IDX_W-1:0]                pos_ff;
   logic                            full_ff;
   logic [bpd_pkg::RUN_W-1:0]       run_ff;
   logic                            flag_ff;

   // working registers
   logic [bpd_pkg::SAMPLE_W-1:0]    raw_ff;
   logic [bpd_pkg::SAMPLE_W-1:0]    gas_ff;
   logic signed [D_W-1:0]           d_ff;
   logic signed [PROD_W-1:0]        prod_ff;
   logic signed [P_W-1:0]           ring_ff [WINDOW];
   logic [CNT_W-1:0]                cnt_ff;
   logic [IDX_W-1:0]                idx_ff;
   logic signed [SUM_W-1:0]         acc_ff;
   logic [DIV_W-1:0]                dvd_ff;
   logic [CNT_W-1:0]                rem_ff;
   logic [STEP_W-1:0]               step_ff;
   logic                            neg_ff;

   // result register
   logic                            out_valid_ff;
   logic                            out_cal_ff;
   logic                            out_blow_ff;
   logic signed [P_W-1:0]           out_filt_ff;
   logic [bpd_pkg::SAMPLE_W-1:0]    out_gas_ff;

   logic cal_active;
   assign cal_active = (cal_taken_ff < CAL_W'(CAL_SAMPLES));

   // raw*cal - baseline at accept
   logic [BASE_W-1:0]     raw_scaled;
   logic signed [D_W-1:0] d_in;
   assign raw_scaled = BASE_W'(pressure_sample) * BASE_W'(CAL_SAMPLES);
   assign d_in = $signed({2'b00, raw_scaled}) - $signed({2'b00, baseline_ff});

   // gain multiply
   logic signed [PROD_W-1:0] d_ext;
   logic signed [PROD_W-1:0] g_ext;
   logic signed [PROD_W-1:0] prod_in;
   assign d_ext   = PROD_W'(d_ff);
   assign g_ext   = $signed({{(PROD_W - bpd_pkg::GAIN_W){1'b0}}, gain_ff});
   assign prod_in = d_ext * g_ext;

   // floor shift and saturation to the q8 range
   logic signed [PROD_W-1:0] shifted;
   logic signed [P_W-1:0]    p_sat;
   logic                     ovf;
   assign shifted = prod_ff >>> bpd_pkg::GAIN_FRAC;
   assign ovf = !((&shifted[PROD_W-1:P_W-1]) || !(|shifted[PROD_W-1:P_W-1]));
   always_comb begin
      if (!ovf)                  p_sat = shifted[P_W-1:0];
      else if (shifted[PROD_W-1]) p_sat = {1'b1, {(P_W-1){1'b0}}};
      else                       p_sat = {1'b0, {(P_W-1){1'b1}}};
   end

   // ring position after this write
   logic             pos_wrap;
   logic [CNT_W-1:0] cnt_in;
   assign pos_wrap = (pos_ff == IDX_W'(WINDOW - 1));
   assign cnt_in   = (full_ff || pos_wrap) ? CNT_W'(WINDOW) : (CNT_W'(pos_ff) + 1'b1);

   // ring entry sign-extended into the accumulator
   logic signed [P_W-1:0]   ring_rd;
   logic signed [SUM_W-1:0] ring_ext;
   assign ring_rd  = ring_ff[idx_ff];
   assign ring_ext = SUM_W'(ring_rd);

   // divider: magnitude in, two quotient bits per step
   logic [SUM_W-1:0]  mag;
   logic [CNT_W:0]    t1, t0;
   logic              q1, q0;
   logic [CNT_W-1:0]  r1, r0;
   assign mag = acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);

   always_comb begin
      t1 = {rem_ff, dvd_ff[DIV_W-1]};
      q1 = (t1 >= {1'b0, cnt_ff});
      r1 = q1 ? CNT_W'(t1 - {1'b0, cnt_ff}) : t1[CNT_W-1:0];
      t0 = {r1, dvd_ff[DIV_W-2]};
      q0 = (t0 >= {1'b0, cnt_ff});
      r0 = q0 ? CNT_W'(t0 - {1'b0, cnt_ff}) : t0[CNT_W-1:0];
   end

   // signed average, threshold compare and run counter
   logic [P_W:0]              quo;
   logic signed [P_W:0]       avg;
   logic                      above;
   logic [bpd_pkg::RUN_W-1:0] run_in;
   logic                      flag_in;
   assign quo   = dvd_ff[P_W:0];
   assign avg   = neg_ff ? -$signed(quo) : $signed(quo);
   assign above = (avg > $signed({2'b00, thresh_ff}));

   always_comb begin
      if (above) begin
         run_in  = (&run_ff) ? run_ff : run_ff + 1'b1;
         flag_in = flag_ff || (run_in >= stable_ff);
      end else begin
         run_in  = '0;
         flag_in = 1'b0;
      end
   end

   assign status.cal_active = cal_active;
   assign status.sum_last   = (CNT_W'(idx_ff) + 1'b1 == cnt_ff);
   assign status.div_last   = (step_ff == STEP_W'(DIV_STEPS - 1));
   assign status.out_free   = !out_valid_ff || rsp_tready;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff  <= '0;
         cal_taken_ff <= '0;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         run_ff       <= '0;
         flag_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.store) begin
            pos_ff <= pos_wrap ? '0 : pos_ff + 1'b1;
            if (pos_wrap) full_ff <= 1'b1;
         end
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
            if (cal_active) begin
               baseline_ff  <= baseline_ff + BASE_W'(raw_ff);
               cal_taken_ff <= cal_taken_ff + 1'b1;
            end else begin
               run_ff  <= run_in;
               flag_ff <= flag_in;
            end
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         raw_ff <= pressure_sample;
         gas_ff <= gas_sample;
         d_ff   <= d_in;
      end
      if (cmd.mult) prod_ff <= prod_in;
      if (cmd.store) begin
         ring_ff[pos_ff] <= p_sat;
         cnt_ff          <= cnt_in;
         acc_ff          <= '0;
         idx_ff          <= '0;
      end
      if (cmd.sum_step) begin
         acc_ff <= acc_ff + ring_ext;
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.div_init) begin
         dvd_ff  <= DIV_W'(mag);
         neg_ff  <= acc_ff[SUM_W-1];
         rem_ff  <= '0;
         step_ff <= '0;
      end
      if (cmd.div_step) begin
         dvd_ff  <= {dvd_ff[DIV_W-3:0], q1, q0};
         rem_ff  <= r0;
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.finish) begin
         if (cal_active) begin
            out_cal_ff  <= 1'b1;
            out_blow_ff <= 1'b0;
            out_filt_ff <= '0;
            out_gas_ff  <= '0;
         end else begin
            out_cal_ff  <= 1'b0;
            out_blow_ff <= flag_in;
            out_filt_ff <= avg[P_W-1:0];
            out_gas_ff  <= flag_in ? gas_ff : '0;
         end
      end
   end

   assign rsp_tvalid        = out_valid_ff;
   assign calibrating       = out_cal_ff;
   assign blowing           = out_blow_ff;
   assign filtered_pressure = out_filt_ff;
   assign gas_reading       = out_gas_ff;

endmodule

### hw/rtl/breath_pressure_detector_top.sv
// ----------------------------------------------------------------------------
// breath_pressure_detector_top
// baseline-calibrated pressure, moving average and debounced blow detection
// ----------------------------------------------------------------------------
//
//  channel  dir  ports                          word
//  req      in   req_tvalid/tready/tdata[23:0]  pressure_sample, gas_sample
//  rsp      out  rsp_tvalid/tready/tdata[31:0]  blowing, filtered_pressure,
//                rsp_tuser                      gas_reading; tuser calibrating
//  csr      in   csr_we/addr[1:0]/wdata[19:0]   gain, threshold, stable count
//
//  one word at a time; a calibration word goes from accept straight to the
//  delivery step; a measurement word passes through the multiply, the store,
//  the ring sum over n entries (one entry a cycle, n being the ring fill,
//  WINDOW once full), the divider setup and the divider (two bits a cycle,
//  12 steps) before the delivery step
//  the result register frees the input side: the next word is accepted while
//  a result waits, and only the final delivery step stalls on rsp_tready
//  reset (synchronous, active high) restarts calibration and clears the ring
//  fill, the run counter and the flag; config returns to its defaults
//
module breath_pressure_detector_top #(
   parameter int WINDOW      = bpd_pkg::WINDOW_DEFAULT,
   parameter int CAL_SAMPLES = bpd_pkg::CAL_SAMPLES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // pressure_sample, gas_sample
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // blowing, filtered_pressure, gas_reading
   output logic                              rsp_tuser,  // calibrating
   // config write port
   input  logic                              csr_we,
   input  logic [bpd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [bpd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   bpd_pkg::cmd_type    cmd;
   bpd_pkg::status_type status;

   // unpacked result fields
   logic                                calibrating;
   logic                                blowing;
   logic signed [bpd_pkg::P_W-1:0]      filtered_pressure;
   logic [bpd_pkg::SAMPLE_W-1:0]        gas_reading;

   // sequencer: owns the input handshake
   bpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // arithmetic, state and the result register
   bpd_datapath #(
      .WINDOW      (WINDOW),
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .pressure_sample   (req_tdata[11:0]),
      .gas_sample        (req_tdata[23:12]),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .rsp_tready        (rsp_tready),
      .rsp_tvalid        (rsp_tvalid),
      .calibrating       (calibrating),
      .blowing           (blowing),
      .filtered_pressure (filtered_pressure),
      .gas_reading       (gas_reading)
   );

   // result word packing; blowing is the lowest field, gas_reading the highest
   assign rsp_tdata = {gas_reading, filtered_pressure, blowing};
   assign rsp_tuser = calibrating;

endmodule
